/* src/irt_pkg.sv */
package irt_pkg;

   localparam int OP_W  = 2;
   localparam int KEY_W = 256;
   localparam int REQ_W = 63;
   localparam int CNT_W = 7;

   // op codes, code 3 behaves as a plain lookup
   localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
   localparam logic [OP_W-1:0] OP_ERASE = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [63:0]      key_word0;
      logic [63:0]      key_word1;
      logic [63:0]      key_word2;
      logic [63:0]      key_word3;
      logic [REQ_W-1:0] requester;
   } irt_req_type;

   typedef struct packed {
      logic             key_present;
      logic             pair_present;
      logic [CNT_W-1:0] key_count;
      logic [REQ_W-1:0] first_requester;
      logic             first_valid;
      logic             all_match;
      logic             changed;
      logic             table_full;
      logic [CNT_W-1:0] total_entries;
   } irt_rsp_type;

   // lookup status handed from the table to the count stage
   typedef struct packed {
      logic             pair_hit;
      logic             first_valid;
      logic [REQ_W-1:0] first_requester;
      logic             changed;
      logic             full;
   } irt_look_type;

endpackage

/* src/irt_table.sv */
module irt_table #(
   parameter int ENTRIES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  irt_pkg::irt_req_type          item,
   input  logic                          fire,
   output logic [ENTRIES-1:0]            match,
   output irt_pkg::irt_look_type         look,
   output logic [$clog2(ENTRIES+1)-1:0]  total_before,
   output logic [$clog2(ENTRIES+1)-1:0]  total_after
);

   localparam int CW = $clog2(ENTRIES + 1);
   localparam int IW = $clog2(ENTRIES);

   logic [irt_pkg::KEY_W-1:0] entry_key_ff [ENTRIES];
   logic [irt_pkg::REQ_W-1:0] entry_req_ff [ENTRIES];
   logic [CW-1:0]             total_ff;
   logic [CW-1:0]             total_in;

   logic [irt_pkg::KEY_W-1:0] key;
   logic [ENTRIES-1:0]        hit_key;
   logic [ENTRIES-1:0]        hit_pair;
   logic [ENTRIES-1:0]        key_lo;
   logic [ENTRIES-1:0]        pair_lo;
   logic [ENTRIES-1:0]        key_first;
   logic [ENTRIES-1:0]        pair_first;
   logic [ENTRIES-1:0]        shift_mask;
   logic [irt_pkg::REQ_W-1:0] first_req;
   logic                      pair_hit;
   logic                      add_ok;
   logic                      erase_ok;
   logic                      full;

   assign key = {item.key_word3, item.key_word2, item.key_word1, item.key_word0};

   // parallel compare of every live entry
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_key[i]  = (CW'(i) < total_ff) && (entry_key_ff[i] == key);
         hit_pair[i] = hit_key[i] && (entry_req_ff[i] == item.requester);
      end
   end

   // lowest set bit and everything below it
   assign key_lo     = hit_key ^ (hit_key - ENTRIES'(1));
   assign pair_lo    = hit_pair ^ (hit_pair - ENTRIES'(1));
   assign key_first  = key_lo & hit_key;
   assign pair_first = pair_lo & hit_pair;
   // entries at or above the erased slot take their upper neighbor
   assign shift_mask = ~pair_lo | pair_first;
   assign pair_hit   = |hit_pair;

   always_comb begin
      first_req = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         first_req |= entry_req_ff[i] & {irt_pkg::REQ_W{key_first[i]}};
      end
   end

   always_comb begin
      add_ok   = 1'b0;
      erase_ok = 1'b0;
      full     = 1'b0;
      unique case (item.op)
         irt_pkg::OP_ADD: begin
            if (!pair_hit) begin
               if (total_ff != CW'(ENTRIES)) begin
                  add_ok = 1'b1;
               end else begin
                  full = 1'b1;
               end
            end
         end
         irt_pkg::OP_ERASE: begin
            erase_ok = pair_hit;
         end
         default: begin
            erase_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      total_in = total_ff;
      if (add_ok) begin
         total_in = total_ff + CW'(1);
      end else if (erase_ok) begin
         total_in = total_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (fire) begin
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && add_ok) begin
         entry_key_ff[total_ff[IW-1:0]] <= key;
         entry_req_ff[total_ff[IW-1:0]] <= item.requester;
      end
      if (fire && erase_ok) begin
         for (int i = 0; i < ENTRIES - 1; i++) begin
            if (shift_mask[i]) begin
               entry_key_ff[i] <= entry_key_ff[i+1];
               entry_req_ff[i] <= entry_req_ff[i+1];
            end
         end
      end
   end

   assign match                = hit_key;
   assign total_before         = total_ff;
   assign total_after          = total_in;
   assign look.pair_hit        = pair_hit;
   assign look.first_valid     = |hit_key;
   assign look.first_requester = first_req;
   assign look.changed         = add_ok || erase_ok;
   assign look.full            = full;

endmodule

/* src/inflight_request_tracker.sv */
// channel  direction  payload               handshake
// req      in         irt_pkg::irt_req_type  req_valid / req_stall
// rsp      out        irt_pkg::irt_rsp_type  rsp_valid / rsp_stall
//
// one item per cycle sustained while rsp_stall is low; rsp_valid rises once an accepted item
// has passed stage 0 and stage 1 into the result register; the table compare and the insert /
// compacting erase settle as the item leaves stage 0, the per-key count is summed in the next stage
// synchronous active-high reset empties the table and all stage valids
// a stall on rsp backs up the three stages, req_stall rises once all are full
// and rsp_stall is still high
module inflight_request_tracker #(
   parameter int ENTRIES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  irt_pkg::irt_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output irt_pkg::irt_rsp_type  rsp_data
);

   localparam int CW = $clog2(ENTRIES + 1);

   // stage 0: input register
   logic                  s0_valid_ff;
   irt_pkg::irt_req_type  s0_item_ff;

   // stage 1: lookup results, table already updated
   logic                  s1_valid_ff;
   logic [ENTRIES-1:0]    s1_match_ff;
   irt_pkg::irt_look_type s1_look_ff;
   logic [CW-1:0]         s1_before_ff;
   logic [CW-1:0]         s1_after_ff;

   // stage 2: result register
   logic                  rsp_valid_ff;
   irt_pkg::irt_rsp_type  rsp_ff;
   irt_pkg::irt_rsp_type  rsp_in;

   logic                  en0;
   logic                  en1;
   logic                  en2;
   logic                  fire0;

   logic [ENTRIES-1:0]    match;
   irt_pkg::irt_look_type look;
   logic [CW-1:0]         total_before;
   logic [CW-1:0]         total_after;
   logic [CW-1:0]         count;

   // a stage loads when it is empty or its contents move on
   assign en2   = !rsp_valid_ff || !rsp_stall;
   assign en1   = !s1_valid_ff || en2;
   assign en0   = !s0_valid_ff || en1;
   // the table commits an item exactly when it leaves stage 0
   assign fire0 = s0_valid_ff && en1;

   assign req_stall = !en0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en0) begin
            s0_valid_ff <= req_valid;
         end
         if (en1) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (en2) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en0 && req_valid) begin
         s0_item_ff <= req_data;
      end
      if (fire0) begin
         s1_match_ff  <= match;
         s1_look_ff   <= look;
         s1_before_ff <= total_before;
         s1_after_ff  <= total_after;
      end
      if (en2 && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   irt_table #(
      .ENTRIES (ENTRIES)
   ) u_table (
      .clock        (clock),
      .reset        (reset),
      .item         (s0_item_ff),
      .fire         (fire0),
      .match        (match),
      .look         (look),
      .total_before (total_before),
      .total_after  (total_after)
   );

   // number of live entries holding the key
   always_comb begin
      count = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         count = count + CW'(s1_match_ff[i]);
      end
   end

   always_comb begin
      rsp_in.key_present     = |s1_match_ff;
      rsp_in.pair_present    = s1_look_ff.pair_hit;
      rsp_in.key_count       = irt_pkg::CNT_W'(count);
      rsp_in.first_requester = s1_look_ff.first_requester;
      rsp_in.first_valid     = s1_look_ff.first_valid;
      // every stored entry carries this key
      rsp_in.all_match       = (s1_before_ff != '0) && (count == s1_before_ff);
      rsp_in.changed         = s1_look_ff.changed;
      rsp_in.table_full      = s1_look_ff.full;
      rsp_in.total_entries   = irt_pkg::CNT_W'(s1_after_ff);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s0_valid_ff && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   // input is held off only when every stage is occupied
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s0_valid_ff && s1_valid_ff && rsp_valid_ff)
      else $error("input stalled with a free stage");

   // a found pair implies a found key with its earliest requester
   a_pair_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.pair_present |-> rsp_ff.key_present && rsp_ff.first_valid)
      else $error("pair found without key");

   // a refused add only happens on a full table and leaves the count alone
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_look_ff.full |->
         s1_before_ff == CW'(ENTRIES) && s1_after_ff == s1_before_ff)
      else $error("full flagged on a table with room");

endmodule

/* verif/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 64;
   localparam int POOL_KEYS   = 6;
   localparam int POOL_REQS   = 8;
   localparam int MAX_WAIT    = 11;
   localparam int MAX_REPORTS = 60;

   // op codes the package leaves unnamed
   localparam logic [irt_pkg::OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [irt_pkg::OP_W-1:0] OP_SPARE  = 2'd3;

   localparam logic [irt_pkg::KEY_W-1:0] KEY_ZERO = '0;
   localparam logic [irt_pkg::KEY_W-1:0] KEY_ONES = '1;
   localparam logic [irt_pkg::REQ_W-1:0] REQ_ZERO = '0;
   localparam logic [irt_pkg::REQ_W-1:0] REQ_MAX  = '1;

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   irt_pkg::irt_req_type req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   irt_pkg::irt_rsp_type rsp_data;

   inflight_request_tracker #(
      .ENTRIES   (TABLE_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop in case the handshake hangs
   initial begin
      #5_000_000;
      $display("inflight_request_tracker verification failed");
      $finish;
   end

   // shadow copy of the tracker table, kept in insertion order
   logic [irt_pkg::KEY_W-1:0] held_key [TABLE_DEPTH];
   logic [irt_pkg::REQ_W-1:0] held_req [TABLE_DEPTH];
   int                        held_total = 0;

   // lookup results owed by the block, oldest first
   irt_pkg::irt_rsp_type pending_results[$];
   int                   error_count = 0;

   // when set, that side never idles (stretches of back-to-back traffic)
   bit sender_eager   = 1'b0;
   bit receiver_eager = 1'b0;

   // small pools so keys and pairs repeat and the table sees real hits
   logic [irt_pkg::KEY_W-1:0] key_pool [POOL_KEYS];
   logic [irt_pkg::REQ_W-1:0] req_pool [POOL_REQS];

   // lookup against the table as it stands, then apply add or erase
   function automatic irt_pkg::irt_rsp_type tracker_apply(input irt_pkg::irt_req_type item);
      irt_pkg::irt_rsp_type      res;
      logic [irt_pkg::KEY_W-1:0] key;
      int                        hits;
      int                        pair_slot;
      res       = '0;
      key       = {item.key_word3, item.key_word2, item.key_word1, item.key_word0};
      hits      = 0;
      pair_slot = 0;
      for (int i = 0; i < held_total; i++) begin
         if (held_key[i] == key) begin
            // earliest matching slot is the earliest-added requester
            if (hits == 0) begin
               res.first_valid     = 1'b1;
               res.first_requester = held_req[i];
            end
            hits++;
            if (!res.pair_present && held_req[i] == item.requester) begin
               res.pair_present = 1'b1;
               pair_slot        = i;
            end
         end
      end
      res.key_present = (hits != 0);
      res.key_count   = irt_pkg::CNT_W'(hits);
      res.all_match   = (held_total != 0) && (hits == held_total);
      if (item.op == irt_pkg::OP_ADD && !res.pair_present) begin
         if (held_total < TABLE_DEPTH) begin
            held_key[held_total] = key;
            held_req[held_total] = item.requester;
            held_total++;
            res.changed = 1'b1;
         end else begin
            // new pair with no room left
            res.table_full = 1'b1;
         end
      end else if (item.op == irt_pkg::OP_ERASE && res.pair_present) begin
         // close the gap so order is kept
         for (int i = pair_slot; i < held_total - 1; i++) begin
            held_key[i] = held_key[i + 1];
            held_req[i] = held_req[i + 1];
         end
         held_total--;
         res.changed = 1'b1;
      end
      res.total_entries = irt_pkg::CNT_W'(held_total);
      return res;
   endfunction

   function automatic logic [irt_pkg::KEY_W-1:0] rand_key();
      logic [irt_pkg::KEY_W-1:0] k;
      for (int w = 0; w < irt_pkg::KEY_W / 32; w++) begin
         k[w*32 +: 32] = $urandom;
      end
      return k;
   endfunction

   function automatic logic [irt_pkg::REQ_W-1:0] rand_req();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[irt_pkg::REQ_W-1:0];
   endfunction

   // mostly pooled keys, now and then a fresh one
   function automatic logic [irt_pkg::KEY_W-1:0] pick_key();
      if ($urandom_range(0, 99) < 85) begin
         return key_pool[$urandom_range(0, POOL_KEYS - 1)];
      end
      return rand_key();
   endfunction

   function automatic logic [irt_pkg::REQ_W-1:0] pick_req();
      if ($urandom_range(0, 99) < 80) begin
         return req_pool[$urandom_range(0, POOL_REQS - 1)];
      end
      return rand_req();
   endfunction

   // present one item, hold it through stalls, predict once accepted
   // valid is left high after acceptance; the next call or a drain lowers it
   task automatic send_item(input logic [irt_pkg::OP_W-1:0] op,
                            input logic [irt_pkg::KEY_W-1:0] key,
                            input logic [irt_pkg::REQ_W-1:0] requester);
      irt_pkg::irt_req_type item;
      int                   gap;
      item.op        = op;
      item.key_word0 = key[63:0];
      item.key_word1 = key[127:64];
      item.key_word2 = key[191:128];
      item.key_word3 = key[255:192];
      item.requester = requester;
      gap = sender_eager ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results = {pending_results, tracker_apply(item)};
   endtask

   // stop sending and wait for every owed result
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic erase_held_entry();
      int slot;
      slot = $urandom_range(0, held_total - 1);
      send_item(irt_pkg::OP_ERASE, held_key[slot], held_req[slot]);
   endtask

   task automatic report_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= MAX_REPORTS) begin
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
         end
      end
   endtask

   // result side: random stall per item, field compare against oldest prediction
   initial begin : result_checker
      irt_pkg::irt_rsp_type want;
      int                   hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            if (pending_results.size() == 0) begin
               error_count++;
               $display("%0t ns: unexpected item, expected none actual %h", $time, rsp_data);
            end else begin
               want = pending_results.pop_front();
               report_field("key_present", 64'(want.key_present),
                            64'(rsp_data.key_present));
               report_field("pair_present", 64'(want.pair_present),
                            64'(rsp_data.pair_present));
               report_field("key_count", 64'(want.key_count), 64'(rsp_data.key_count));
               report_field("first_requester", 64'(want.first_requester),
                            64'(rsp_data.first_requester));
               report_field("first_valid", 64'(want.first_valid),
                            64'(rsp_data.first_valid));
               report_field("all_match", 64'(want.all_match), 64'(rsp_data.all_match));
               report_field("changed", 64'(want.changed), 64'(rsp_data.changed));
               report_field("table_full", 64'(want.table_full), 64'(rsp_data.table_full));
               report_field("total_entries", 64'(want.total_entries),
                            64'(rsp_data.total_entries));
            end
            hold = receiver_eager ? 0 : $urandom_range(0, MAX_WAIT);
         end else if (hold > 0) begin
            hold--;
         end
         rsp_stall <= (hold != 0);
      end
   end

   // corner cases on a table that starts empty after reset
   task automatic test_directed();
      logic [irt_pkg::KEY_W-1:0] near_key;
      near_key          = KEY_ONES;
      near_key[191:128] = '0;
      // empty table, both lookup codes
      send_item(OP_LOOKUP, KEY_ZERO, REQ_ZERO);
      send_item(OP_SPARE, KEY_ONES, REQ_MAX);
      // one key, several requesters, duplicate add ignored
      send_item(irt_pkg::OP_ADD, KEY_ONES, REQ_MAX);
      send_item(irt_pkg::OP_ADD, KEY_ONES, REQ_MAX);
      send_item(irt_pkg::OP_ADD, KEY_ONES, REQ_ZERO);
      send_item(irt_pkg::OP_ADD, KEY_ONES, 63'd5);
      // every entry holds this key
      send_item(OP_SPARE, KEY_ONES, REQ_ZERO);
      send_item(irt_pkg::OP_ADD, KEY_ZERO, REQ_MAX);
      send_item(OP_LOOKUP, KEY_ONES, REQ_MAX);
      // erase from the middle, then the earliest, order must hold
      send_item(irt_pkg::OP_ERASE, KEY_ONES, REQ_ZERO);
      send_item(OP_LOOKUP, KEY_ONES, REQ_ZERO);
      send_item(irt_pkg::OP_ERASE, KEY_ONES, REQ_MAX);
      send_item(OP_LOOKUP, KEY_ONES, REQ_ZERO);
      // key present but pair absent
      send_item(irt_pkg::OP_ERASE, KEY_ZERO, REQ_ZERO);
      // key that differs in a single word
      send_item(irt_pkg::OP_ADD, near_key, 63'd5);
      send_item(OP_LOOKUP, near_key, REQ_MAX);
      send_item(OP_LOOKUP, KEY_ONES, 63'd5);
      // empty it again
      send_item(irt_pkg::OP_ERASE, KEY_ONES, 63'd5);
      send_item(irt_pkg::OP_ERASE, near_key, 63'd5);
      send_item(irt_pkg::OP_ERASE, KEY_ZERO, REQ_MAX);
      send_item(OP_LOOKUP, KEY_ZERO, REQ_ZERO);
   endtask

   // fill to capacity, overflow, duplicate at full, then drain by erase
   task automatic test_fill_and_overflow();
      int slot;
      // sender holds off until the block has answered everything
      wait_drained();
      sender_eager   = 1'b1;
      receiver_eager = 1'b1;
      while (held_total < TABLE_DEPTH) begin
         send_item(irt_pkg::OP_ADD, pick_key(), rand_req());
      end
      sender_eager   = 1'b0;
      receiver_eager = 1'b0;
      send_item(irt_pkg::OP_ADD, rand_key(), rand_req());
      slot = $urandom_range(0, held_total - 1);
      // duplicate while full is neither stored nor flagged
      send_item(irt_pkg::OP_ADD, held_key[slot], held_req[slot]);
      send_item(OP_SPARE, held_key[slot], held_req[slot]);
      erase_held_entry();
      send_item(irt_pkg::OP_ADD, key_pool[0], REQ_MAX);
      send_item(irt_pkg::OP_ADD, rand_key(), rand_req());
      while (held_total > 0) begin
         erase_held_entry();
      end
   endtask

   // segments alternate between filling and draining pressure
   task automatic test_random_traffic();
      int add_weight;
      int roll;
      for (int seg = 0; seg < 10; seg++) begin
         add_weight     = (seg % 3 == 0) ? 65 : ((seg % 3 == 1) ? 40 : 20);
         sender_eager   = ($urandom_range(0, 3) == 0);
         receiver_eager = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < 100; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < add_weight) begin
               send_item(irt_pkg::OP_ADD, pick_key(), pick_req());
            end else if (roll < 90 && held_total > 0 && $urandom_range(0, 3) != 0) begin
               // erase of a pair known to be stored
               erase_held_entry();
            end else if (roll < 90) begin
               send_item(irt_pkg::OP_ERASE, pick_key(), pick_req());
            end else begin
               send_item(($urandom_range(0, 1) != 0) ? OP_LOOKUP : OP_SPARE,
                         pick_key(), pick_req());
            end
         end
      end
      sender_eager   = 1'b0;
      receiver_eager = 1'b0;
   endtask

   initial begin : run_tests
      key_pool[0] = KEY_ZERO;
      key_pool[1] = KEY_ONES;
      for (int i = 2; i < POOL_KEYS; i++) begin
         key_pool[i] = rand_key();
      end
      req_pool[0] = REQ_ZERO;
      req_pool[1] = REQ_MAX;
      for (int i = 2; i < POOL_REQS; i++) begin
         req_pool[i] = rand_req();
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill_and_overflow();
      test_random_traffic();
      wait_drained();
      // catch any stray item past the pipeline depth
      repeat (12) @(posedge clock);
      if (error_count == 0) begin
         $display("inflight_request_tracker verification clean");
      end else begin
         $display("inflight_request_tracker verification failed");
      end
      $finish;
   end

endmodule
